// ===== rtl/rsd_pkg.sv =====
// Shared types and constants for the Renard stream deframer.
package rsd_pkg;

    localparam int SLOT_W = 5;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7F;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

    localparam logic [BYTE_W-1:0] ESC_CODE_PAD  = 8'h2F;
    localparam logic [BYTE_W-1:0] ESC_CODE_SYNC = 8'h30;
    localparam logic [BYTE_W-1:0] ESC_CODE_ESC  = 8'h31;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SYNC = 2'd1,
        MODE_ESC  = 2'd2
    } mode_t;

    typedef enum logic {
        ST_RUN = 1'b0,
        ST_PAD = 1'b1
    } state_t;

    typedef struct packed {
        logic take;
        logic pad;
    } rsd_cmd_t;

    typedef struct packed {
        logic is_sync;
        logic fill_zero;
        logic pad_last;
        logic out_free;
    } rsd_status_t;

endpackage

// ===== rtl/rsd_ctrl.sv =====
// Controller state machine: input handshake and zero-padding sequence.
module rsd_ctrl
    import rsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rsd_status_t status,
    output rsd_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_valid && status.out_free && status.is_sync && !status.fill_zero) begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                if (status.out_free && status.pad_last) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.take = 1'b0;
        cmd.pad  = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                s_ready  = status.out_free;
                cmd.take = s_valid && status.out_free;
            end
            ST_PAD: begin
                cmd.pad = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/rsd_datapath.sv =====
// Datapath: byte decoding, frame counters and the output register.
module rsd_datapath
    import rsd_pkg::*;
#(
    parameter int FRAME_BYTES = 30
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] rx_byte,
    input  rsd_cmd_t          cmd,
    output rsd_status_t       status,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_channel_byte,
    output logic [SLOT_W-1:0] m_slot_index,
    output logic [BYTE_W-1:0] m_frame_number,
    output logic              m_frame_last
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_BYTES - 1);

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [SLOT_W-1:0] fill_reg;
    logic [SLOT_W-1:0] fill_next;
    logic [BYTE_W-1:0] frame_reg;
    logic [BYTE_W-1:0] frame_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [SLOT_W-1:0] out_slot_next;
    logic [BYTE_W-1:0] out_frame_reg;
    logic [BYTE_W-1:0] out_frame_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              is_pad;
    logic              is_sync;
    logic              is_esc;
    logic              is_addr;
    logic              emits;
    logic              fill_last;
    logic              load;
    logic [BYTE_W-1:0] dec_byte;

    assign is_pad    = (rx_byte == PAD_BYTE);
    assign is_sync   = (rx_byte == SYNC_BYTE);
    assign is_esc    = (rx_byte == ESC_BYTE);
    assign is_addr   = !is_pad && !is_sync && !is_esc && (mode_reg == MODE_SYNC);
    assign emits     = !is_pad && !is_sync && !is_esc && (mode_reg != MODE_SYNC);
    assign fill_last = (fill_reg == LAST_SLOT);
    assign load      = (cmd.take && emits) || cmd.pad;

    always_comb begin
        dec_byte = rx_byte;
        if (mode_reg == MODE_ESC) begin
            case (rx_byte)
                ESC_CODE_PAD:  dec_byte = PAD_BYTE;
                ESC_CODE_SYNC: dec_byte = SYNC_BYTE;
                ESC_CODE_ESC:  dec_byte = ESC_BYTE;
                default:       dec_byte = rx_byte;
            endcase
        end
    end

    always_comb begin
        mode_next      = mode_reg;
        fill_next      = fill_reg;
        frame_next     = frame_reg;
        out_byte_next  = out_byte_reg;
        out_slot_next  = out_slot_reg;
        out_frame_next = out_frame_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (cmd.take && !is_pad) begin
            if (is_sync) begin
                mode_next = MODE_SYNC;
            end else if (is_esc) begin
                mode_next = MODE_ESC;
            end else begin
                mode_next = MODE_IDLE;
            end
        end

        if (cmd.take && is_addr) begin
            frame_next = '0;
        end

        if (load) begin
            out_valid_next = 1'b1;
            out_byte_next  = cmd.pad ? ZERO_BYTE : dec_byte;
            out_slot_next  = fill_reg;
            out_frame_next = frame_reg;
            out_last_next  = fill_last;
            if (fill_last) begin
                fill_next  = '0;
                frame_next = frame_reg + 8'd1;
            end else begin
                fill_next = fill_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            fill_reg      <= '0;
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            fill_reg      <= fill_next;
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg  <= out_byte_next;
        out_slot_reg  <= out_slot_next;
        out_frame_reg <= out_frame_next;
        out_last_reg  <= out_last_next;
    end

    assign status.is_sync   = is_sync;
    assign status.fill_zero = (fill_reg == '0);
    assign status.pad_last  = fill_last;
    assign status.out_free  = !out_valid_reg || m_ready;

    assign m_valid        = out_valid_reg;
    assign m_channel_byte = out_byte_reg;
    assign m_slot_index   = out_slot_reg;
    assign m_frame_number = out_frame_reg;
    assign m_frame_last   = out_last_reg;

endmodule

// ===== rtl/renard_stream_deframer_top.sv =====
// A channel byte appears on the result port in the cycle after its item is accepted.
// Throughput: one input item per cycle while the result side keeps up.
// A sync byte that closes a part-filled frame stalls the input until the remaining slots are
// filled; the pad sequencer emits zero bytes, one per cycle while the result side keeps up.
// Reset is synchronous and active low; it clears the parse mode, both counters and m_valid.
module renard_stream_deframer_top
    import rsd_pkg::*;
#(
    parameter int FRAME_BYTES = 30
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_channel_byte,
    output logic [SLOT_W-1:0] m_slot_index,
    output logic [BYTE_W-1:0] m_frame_number,
    output logic              m_frame_last
);

    rsd_cmd_t    cmd;
    rsd_status_t status;

    rsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rsd_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .rx_byte        (s_rx_byte),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_channel_byte (m_channel_byte),
        .m_slot_index   (m_slot_index),
        .m_frame_number (m_frame_number),
        .m_frame_last   (m_frame_last)
    );

`ifndef NO_ASSERTIONS
    a_sync_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_rx_byte == SYNC_BYTE && !status.fill_zero) |=> !s_ready)
        else $error("input not stalled while a frame is padded");

    a_pad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pad |=> (m_valid && m_channel_byte == ZERO_BYTE))
        else $error("pad item is not a zero byte");

    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_last) |-> (m_slot_index == SLOT_W'(FRAME_BYTES - 1)))
        else $error("frame closed at the wrong slot");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_last) |-> (m_slot_index < SLOT_W'(FRAME_BYTES - 1)))
        else $error("slot index beyond the frame");
`endif

endmodule
